FILE: rtl/sds_pkg.sv
`timescale 1ns / 1ps
// shared constants, action codes and address helper for the subset distance sum block
// no dependencies

package sds_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int DIST_BITS    = 24;

    localparam int IDX_BITS  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int DEPTH     = MAX_ELEMENTS * MAX_ELEMENTS;
    localparam int ADDR_BITS = $clog2(DEPTH);

    // fixed field widths of the ports
    localparam int ACTION_W  = 2;
    localparam int INDEX_W   = 6;
    localparam int DIST_IN_W = 24;
    localparam int MASK_W    = 64;
    localparam int SUM_W     = 35;
    localparam int COUNT_W   = 7;
    // one bit above the result, enough for the doubled sum before halving
    localparam int ACC_W     = SUM_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE   = 2'd0,
        ACT_FITNESS = 2'd1,
        ACT_CONTRIB = 2'd2
    } t_action;

    function automatic logic [ADDR_BITS-1:0] entry_addr(
        input logic [IDX_BITS-1:0] row,
        input logic [IDX_BITS-1:0] col
    );
        logic [ADDR_BITS-1:0] base;
        base = ADDR_BITS'(row) * ADDR_BITS'(MAX_ELEMENTS);
        return base + ADDR_BITS'(col);
    endfunction

    function automatic logic index_in_range(input logic [INDEX_W-1:0] v);
        return (COUNT_W'(v) < COUNT_W'(MAX_ELEMENTS));
    endfunction

endpackage

FILE: rtl/subset_distance_sum.sv
`timescale 1ns / 1ps
// top level: distance matrix in one ram, sequencer that writes, scans and sums it
// depends on sds_pkg and sds_ram

// Subset distance sum. After reset the block runs a clearing pass over the whole
// distance matrix, one entry a cycle, with busy high. An item is taken when start
// is high and busy low. A distance write stores both mirrored entries one after
// the other through the single ram port; a subset fitness query reads every
// matrix entry, one a cycle; an element contribution reads one row. Ignored
// writes, out-of-range queries and the unused action answer in the cycle after
// they are taken. The result appears on o_sum_value for exactly one cycle with
// o_done high, and busy is low again in that same cycle; the receiver cannot stall
// it, so it must take every result as it comes. element_count may be written at
// any idle time through the configuration channel, which is always ready.

module subset_distance_sum (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sds_pkg::ACTION_W-1:0]      i_action,
    input  logic [sds_pkg::INDEX_W-1:0]       i_row_index,
    input  logic [sds_pkg::INDEX_W-1:0]       i_col_index,
    input  logic [sds_pkg::DIST_IN_W-1:0]     i_distance,
    input  logic [sds_pkg::MASK_W-1:0]        i_selection_mask,
    output logic                              o_done,
    output logic [sds_pkg::SUM_W-1:0]         o_sum_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sds_pkg::COUNT_W-1:0]       i_cfg_data
);

    import sds_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE2,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    t_state                  r_state;
    logic [ADDR_BITS-1:0]    r_clr_addr;
    logic [COUNT_W-1:0]      r_count;
    t_action                 r_action;
    logic [MAX_ELEMENTS-1:0] r_sel;
    logic [IDX_BITS-1:0]     r_row;
    logic [IDX_BITS-1:0]     r_col;
    logic [ADDR_BITS-1:0]    r_waddr;
    logic [DIST_BITS-1:0]    r_wdata;
    logic                    r_rd_valid;
    logic                    r_rd_inc;
    logic [ACC_W-1:0]        r_acc;
    logic                    r_done;
    logic [SUM_W-1:0]        r_sum;

    logic [COUNT_W-1:0]      n_limit;
    logic [MAX_ELEMENTS-1:0] n_sel;
    logic [ACC_W-1:0]        n_addend;
    logic [ACC_W-1:0]        n_total;
    logic                    n_last;
    logic                    n_write_ok;
    logic                    n_accept;

    logic                    ram_we;
    logic [ADDR_BITS-1:0]    ram_addr;
    logic [DIST_BITS-1:0]    ram_wdata;
    logic [DIST_BITS-1:0]    ram_rdata;

    sds_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != ST_IDLE);
    assign n_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_sum_value = r_sum;

    // selection bits at or above the element count drop out
    always_comb begin
        n_limit = (r_count > COUNT_W'(MAX_ELEMENTS)) ? COUNT_W'(MAX_ELEMENTS) : r_count;
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            n_sel[i] = i_selection_mask[i] && (COUNT_W'(i) < n_limit);
        end
    end

    assign n_write_ok = (i_row_index != i_col_index) && index_in_range(i_row_index)
                        && index_in_range(i_col_index);

    assign n_addend = (r_rd_valid && r_rd_inc) ? ACC_W'(ram_rdata) : '0;
    assign n_total  = r_acc + n_addend;

    assign n_last = (r_col == IDX_BITS'(MAX_ELEMENTS - 1))
                    && ((r_action == ACT_CONTRIB) || (r_row == IDX_BITS'(MAX_ELEMENTS - 1)));

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = entry_addr(r_row, r_col);
        ram_wdata = r_wdata;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr_addr;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                // first half of a write goes straight in on the accepting edge
                if (n_accept && (t_action'(i_action) == ACT_WRITE) && n_write_ok) begin
                    ram_we    = 1'b1;
                    ram_addr  = entry_addr(IDX_BITS'(i_row_index), IDX_BITS'(i_col_index));
                    ram_wdata = DIST_BITS'(i_distance);
                end
            end
            ST_WRITE2: begin
                ram_we   = 1'b1;
                ram_addr = r_waddr;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_count    <= COUNT_RESET;
            r_rd_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_done     <= 1'b0;
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_BITS'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (n_accept) begin
                        r_sel      <= n_sel;
                        r_acc      <= '0;
                        r_rd_valid <= 1'b0;
                        r_col      <= '0;
                        r_wdata    <= DIST_BITS'(i_distance);
                        r_waddr    <= entry_addr(IDX_BITS'(i_col_index),
                                                 IDX_BITS'(i_row_index));
                        case (t_action'(i_action))
                            ACT_WRITE: begin
                                r_action <= ACT_WRITE;
                                if (n_write_ok) begin
                                    r_done  <= 1'b0;
                                    r_state <= ST_WRITE2;
                                end else begin
                                    r_done <= 1'b1;
                                    r_sum  <= '0;
                                end
                            end
                            ACT_FITNESS: begin
                                r_done   <= 1'b0;
                                r_action <= ACT_FITNESS;
                                r_row    <= '0;
                                r_state  <= ST_SCAN;
                            end
                            ACT_CONTRIB: begin
                                r_action <= ACT_CONTRIB;
                                r_row    <= IDX_BITS'(i_row_index);
                                if (index_in_range(i_row_index)) begin
                                    r_done  <= 1'b0;
                                    r_state <= ST_SCAN;
                                end else begin
                                    r_done <= 1'b1;
                                    r_sum  <= '0;
                                end
                            end
                            default: begin
                                r_done <= 1'b1;
                                r_sum  <= '0;
                            end
                        endcase
                    end else begin
                        r_done <= 1'b0;
                    end
                end
                ST_WRITE2: begin
                    r_done  <= 1'b1;
                    r_sum   <= '0;
                    r_state <= ST_IDLE;
                end
                ST_SCAN: begin
                    r_done     <= 1'b0;
                    r_acc      <= n_total;
                    r_rd_valid <= 1'b1;
                    if (r_action == ACT_CONTRIB) begin
                        r_rd_inc <= r_sel[r_col];
                    end else begin
                        r_rd_inc <= r_sel[r_row] && r_sel[r_col];
                    end
                    if (r_col == IDX_BITS'(MAX_ELEMENTS - 1)) begin
                        r_col <= '0;
                        if (r_action != ACT_CONTRIB) begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    if (n_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // last read word lands now, fold it in and halve for fitness
                    r_rd_valid <= 1'b0;
                    r_done     <= 1'b1;
                    if (r_action == ACT_FITNESS) begin
                        r_sum <= n_total[ACC_W-1:1];
                    end else begin
                        r_sum <= n_total[SUM_W-1:0];
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_DRAIN || r_state == ST_WRITE2
                         || (r_state == ST_IDLE && start)))
        else $error("done strobe without a finishing transaction");

    a_scan_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> r_rd_valid)
        else $error("scan cycle issued no read");

    a_drain_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> r_rd_valid)
        else $error("drain without a pending read word");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_DRAIN) |-> !ram_we)
        else $error("store written during a scan");

    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE2) |=> (o_done && o_sum_value == '0))
        else $error("write transaction did not end with a zero result");

endmodule

FILE: rtl/sds_ram.sv
`timescale 1ns / 1ps
// generic single-port ram with a registered read
// no dependencies

module sds_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
